/* src/rtp_pkg.sv */
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared constants, pipeline types and the CORDIC arctangent table for the
// rectangular to polar converter.
// ----------------------------------------------------------------------------
package rtp_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int ANGLE_FRAC_DEF  = 7;

  localparam int CORDIC_ITERS = 32;
  localparam int NORM_MSB     = 56;
  localparam int SHIFT_W      = $clog2(NORM_MSB + 1);
  localparam int CW           = 62;
  localparam int ZW           = 42;

  localparam int FRONT_STG = 3;
  localparam int BACK_STG  = 2;
  localparam int NSTG      = FRONT_STG + CORDIC_ITERS + BACK_STG;

  localparam logic [63:0] RAD2DEG_Q25 = 64'd1922527338;

  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic x_neg;
    logic y_neg;
  } axis_flags_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    axis_flags_t          flags;
  } cordic_t;

  // one term of the arctangent series: p divided by the k-th odd number
  function automatic logic [63:0] odd_term(input logic [63:0] p, input int k);
    logic [63:0] t;
    case (k)
      0:       t = p / 64'd1;
      1:       t = p / 64'd3;
      2:       t = p / 64'd5;
      3:       t = p / 64'd7;
      4:       t = p / 64'd9;
      5:       t = p / 64'd11;
      6:       t = p / 64'd13;
      7:       t = p / 64'd15;
      8:       t = p / 64'd17;
      9:       t = p / 64'd19;
      10:      t = p / 64'd21;
      11:      t = p / 64'd23;
      12:      t = p / 64'd25;
      13:      t = p / 64'd27;
      14:      t = p / 64'd29;
      15:      t = p / 64'd31;
      16:      t = p / 64'd33;
      17:      t = p / 64'd35;
      18:      t = p / 64'd37;
      19:      t = p / 64'd39;
      20:      t = p / 64'd41;
      21:      t = p / 64'd43;
      22:      t = p / 64'd45;
      23:      t = p / 64'd47;
      24:      t = p / 64'd49;
      25:      t = p / 64'd51;
      26:      t = p / 64'd53;
      27:      t = p / 64'd55;
      28:      t = p / 64'd57;
      29:      t = p / 64'd59;
      default: t = '0;
    endcase
    return t;
  endfunction

  // atan(2^-i) in degrees, Q32
  function automatic logic [63:0] atan_q32(input int i);
    logic [63:0] rad;
    logic [63:0] term;
    int          e;
    int          k;
    rad = '0;
    if (i == 0) begin
      return 64'd45 << 32;
    end
    for (k = 0; k < 30; k++) begin
      e = i * (2 * k + 1);
      if (e <= 60) begin
        term = odd_term(64'd1 << (60 - e), k);
        if (k % 2 == 1) begin
          rad = rad - term;
        end else begin
          rad = rad + term;
        end
      end
    end
    return ((rad >> 26) * RAD2DEG_Q25) >> 27;
  endfunction

endpackage

/* src/rtp_pipe_ctrl.sv */
// ----------------------------------------------------------------------------
// rtp_pipe_ctrl
// Per-stage valid bits and load enables; bubbles collapse, stalls hold.
// ----------------------------------------------------------------------------
module rtp_pipe_ctrl
  import rtp_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [NSTG-1:0] en
);

  logic [NSTG-1:0] vld;

  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = out_ready | ~(&vld[NSTG-1:k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTG-1];

endmodule

/* src/rtp_cordic_stage.sv */
// ----------------------------------------------------------------------------
// rtp_cordic_stage
// One registered CORDIC vectoring rotation.
// ----------------------------------------------------------------------------
module rtp_cordic_stage
  import rtp_pkg::*;
#(
  parameter int                   SHIFT = 0,
  parameter logic signed [ZW-1:0] ANGLE = '0
) (
  input  logic    clk,
  input  logic    en,
  input  cordic_t d,
  output cordic_t q
);

  cordic_t              q_next;
  logic signed [CW-1:0] xi;
  logic signed [CW-1:0] yi;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  always_comb begin
    xi     = d.x;
    yi     = d.y;
    dx     = yi >>> SHIFT;
    dy     = xi >>> SHIFT;
    q_next = d;
    if (!yi[CW-1]) begin
      q_next.x = xi + dx;
      q_next.y = yi - dy;
      q_next.z = d.z + ANGLE;
    end else begin
      q_next.x = xi - dx;
      q_next.y = yi + dy;
      q_next.z = d.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

/* src/rtp_angle.sv */
// ----------------------------------------------------------------------------
// rtp_angle
// Angle path: normalise and fold, CORDIC chain, round, unfold and clamp.
// ----------------------------------------------------------------------------
module rtp_angle
  import rtp_pkg::*;
#(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  logic                              clk,
  input  logic [NSTG-1:0]                   en,
  input  logic signed [COORD_WIDTH-1:0]     x_coord,
  input  logic signed [COORD_WIDTH-1:0]     y_coord,
  output logic signed [8+ANGLE_FRAC_BITS:0] angle_deg
);

  localparam int W  = COORD_WIDTH;
  localparam int F  = ANGLE_FRAC_BITS;
  localparam int AW = 9 + F;
  localparam int RW = AW + 2;
  localparam int LW = $clog2(W);

  localparam logic signed [RW-1:0] FULL = RW'(180 * (2 ** F));
  localparam logic signed [RW-1:0] HALF = RW'(90 * (2 ** F));
  localparam logic signed [ZW-1:0] RND  = ZW'(64'd1 << (31 - F));

  // stage 0: magnitudes and axis flags
  logic signed [W-1:0] x0;
  logic signed [W-1:0] y0;
  logic [W-1:0]        ax0;
  logic [W-1:0]        ay0;
  axis_flags_t         f0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0        <= x_coord;
      y0        <= y_coord;
      ax0       <= x_coord[W-1] ? unsigned'(-x_coord) : unsigned'(x_coord);
      ay0       <= y_coord[W-1] ? unsigned'(-y_coord) : unsigned'(y_coord);
      f0.x_zero <= (x_coord == '0);
      f0.y_zero <= (y_coord == '0);
      f0.x_neg  <= x_coord[W-1];
      f0.y_neg  <= y_coord[W-1];
    end
  end

  // stage 1: leading-one search
  logic [W-1:0]         span;
  logic [LW-1:0]        lead;
  logic signed [W-1:0]  x1;
  logic signed [W-1:0]  y1;
  logic [SHIFT_W-1:0]   sh1;
  axis_flags_t          f1;

  always_comb begin
    span = ax0 | ay0;
    lead = '0;
    for (int b = 0; b < W; b++) begin
      if (span[b]) begin
        lead = LW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1  <= x0;
      y1  <= y0;
      sh1 <= SHIFT_W'(NORM_MSB) - SHIFT_W'(lead);
      f1  <= f0;
    end
  end

  // stage 2: scale and fold into the right half plane
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  cordic_t              c_head_next;
  cordic_t              c_head;

  always_comb begin
    xs = CW'(x1) <<< sh1;
    ys = CW'(y1) <<< sh1;
    if (f1.x_neg) begin
      xs = -xs;
      ys = -ys;
    end
    c_head_next.x     = xs;
    c_head_next.y     = ys;
    c_head_next.z     = '0;
    c_head_next.flags = f1;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_head <= c_head_next;
    end
  end

  cordic_t chain [CORDIC_ITERS+1];
  assign chain[0] = c_head;

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    rtp_cordic_stage #(
      .SHIFT (i),
      .ANGLE (ZW'(atan_q32(i)))
    ) u_stage (
      .clk (clk),
      .en  (en[FRONT_STG+i]),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  // round to the output fraction
  cordic_t              c_end;
  logic signed [ZW-1:0] z_rnd;
  logic signed [RW-1:0] res1;
  axis_flags_t          f_r;

  always_comb begin
    c_end = chain[CORDIC_ITERS];
    z_rnd = c_end.z + RND;
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-2]) begin
      res1 <= RW'(z_rnd >>> (32 - F));
      f_r  <= c_end.flags;
    end
  end

  // unfold, clamp, axis cases
  logic signed [RW-1:0] unfold;
  logic signed [RW-1:0] clamp;
  logic signed [RW-1:0] ang_next;

  always_comb begin
    unfold = res1;
    if (f_r.x_neg) begin
      unfold = f_r.y_neg ? res1 - FULL : res1 + FULL;
    end
    if (unfold > FULL) begin
      clamp = FULL;
    end else if (unfold < -FULL) begin
      clamp = -FULL;
    end else begin
      clamp = unfold;
    end
    if (f_r.x_zero && f_r.y_zero) begin
      ang_next = '0;
    end else if (f_r.y_zero) begin
      ang_next = f_r.x_neg ? FULL : '0;
    end else if (f_r.x_zero) begin
      ang_next = f_r.y_neg ? -HALF : HALF;
    end else begin
      ang_next = clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      angle_deg <= AW'(ang_next);
    end
  end

endmodule

/* src/rtp_mag.sv */
// ----------------------------------------------------------------------------
// rtp_mag
// Magnitude path: squares, sum, one root bit per stage, round, delay line.
// ----------------------------------------------------------------------------
module rtp_mag
  import rtp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic [NSTG-1:0]               en,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  output logic [COORD_WIDTH-1:0]        magnitude
);

  localparam int W   = COORD_WIDTH;
  localparam int SW  = 2 * W;
  localparam int PAD = NSTG - 3 - W;

  logic [SW-1:0] xsq;
  logic [SW-1:0] ysq;
  logic [SW-1:0] sum;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xsq <= unsigned'(SW'(x_coord) * SW'(x_coord));
      ysq <= unsigned'(SW'(y_coord) * SW'(y_coord));
    end
    if (en[1]) begin
      sum <= xsq + ysq;
    end
  end

  logic [SW-1:0] root [W];
  logic [SW-1:0] rest [W];

  for (genvar k = 0; k < W; k++) begin : g_root
    localparam logic [SW:0] BIT = (SW+1)'(1) << (SW - 2 - 2 * k);

    logic [SW-1:0] r_in;
    logic [SW-1:0] rest_in;
    logic [SW:0]   trial;

    if (k == 0) begin : g_first
      assign r_in    = '0;
      assign rest_in = sum;
    end else begin : g_next
      assign r_in    = root[k-1];
      assign rest_in = rest[k-1];
    end

    assign trial = {1'b0, r_in} + BIT;

    always_ff @(posedge clk) begin
      if (en[2+k]) begin
        if ({1'b0, rest_in} >= trial) begin
          rest[k] <= rest_in - trial[SW-1:0];
          root[k] <= (r_in >> 1) + BIT[SW-1:0];
        end else begin
          rest[k] <= rest_in;
          root[k] <= r_in >> 1;
        end
      end
    end
  end

  logic [W-1:0] mag_q [PAD+1];

  always_ff @(posedge clk) begin
    if (en[2+W]) begin
      mag_q[0] <= (rest[W-1] > root[W-1]) ? W'(root[W-1] + 1'b1) : W'(root[W-1]);
    end
  end

  for (genvar j = 1; j <= PAD; j++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en[2+W+j]) begin
        mag_q[j] <= mag_q[j-1];
      end
    end
  end

  assign magnitude = mag_q[PAD];

endmodule

/* src/rect_to_polar_converter_top.sv */
// ----------------------------------------------------------------------------
// rect_to_polar_converter_top
// Cartesian point to rounded magnitude and atan2 angle in degrees.
// ----------------------------------------------------------------------------
// Stages: three front stages, a 32-stage CORDIC chain and two back stages.
// Throughput: one beat per cycle; a stalled output holds, and idle stages
//   keep taking beats until every stage is full.
// Reset: rst clears every stage valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
module rect_to_polar_converter_top
  import rtp_pkg::*;
#(
  parameter  int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter  int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF,
  localparam int IN_W            = ((2 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W           = ((COORD_WIDTH + 9 + ANGLE_FRAC_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // x_coord, y_coord
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // magnitude, angle_deg
);

  localparam int W  = COORD_WIDTH;
  localparam int AW = 9 + ANGLE_FRAC_BITS;

  logic [NSTG-1:0]      en;
  logic signed [W-1:0]  x_coord;
  logic signed [W-1:0]  y_coord;
  logic [W-1:0]         magnitude;
  logic signed [AW-1:0] angle_deg;

  assign x_coord = signed'(s_tdata[W-1:0]);
  assign y_coord = signed'(s_tdata[2*W-1:W]);

  rtp_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .en        (en)
  );

  rtp_angle #(
    .COORD_WIDTH     (COORD_WIDTH),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_angle (
    .clk       (clk),
    .en        (en),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .angle_deg (angle_deg)
  );

  rtp_mag #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mag (
    .clk       (clk),
    .en        (en),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .magnitude (magnitude)
  );

  assign m_tdata = OUT_W'({angle_deg, magnitude});

endmodule

/* src/rtp_checker.sv */
// ----------------------------------------------------------------------------
// rtp_checker
// Port-level checks on the converter's input and output streams, bound to the top level.
// ----------------------------------------------------------------------------
module rtp_checker
  import rtp_pkg::*;
#(
  parameter  int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter  int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF,
  localparam int OUT_W           = ((COORD_WIDTH + 9 + ANGLE_FRAC_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  localparam int AW = 9 + ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] FULL = AW'(180 * (2 ** ANGLE_FRAC_BITS));

  logic [COORD_WIDTH-1:0] mag;
  logic signed [AW-1:0]   ang;
  logic                   in_beat;

  assign mag     = m_tdata[COORD_WIDTH-1:0];
  assign ang     = signed'(m_tdata[COORD_WIDTH+AW-1:COORD_WIDTH]);
  assign in_beat = s_tvalid && s_tready;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat offered straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed or dropped");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input refused while the output is free");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ang <= FULL && ang >= -FULL)
    else $error("angle outside half turn");

  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && mag == '0 && !in_beat |-> ang == '0)
    else $error("zero length with non-zero angle");

endmodule

bind rect_to_polar_converter_top rtp_checker #(
  .COORD_WIDTH     (COORD_WIDTH),
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_rtp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
